// ----- src/rftb_pkg.sv -----
// Shared widths, request codes and the token type for the ring finger table builder.
// Used by the cell, the top level and the checker; depends on nothing.
package rftb_pkg;

    // Fixed field widths.
    localparam int IDX_W     = 8;
    localparam int ID_W      = 16;
    localparam int CNT_W     = 9;
    localparam int FINGER_W  = 4;

    // Table size and defaults.
    localparam int MAX_NODES         = 256;
    localparam int RING_BITS_DEFAULT = 16;
    localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 9'd256;

    // Request commands.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Control part of a finger token as it walks down the cell chain.
    typedef struct packed {
        logic                valid;
        logic                found;
        logic                last;
        logic [FINGER_W-1:0] finger;
        logic [IDX_W-1:0]    succ_index;
        logic [ID_W-1:0]     succ_id;
    } token_t;

endpackage

// ----- src/rftb_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rftb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/rftb_cell.sv -----
// One cell of the search chain: holds one table entry and checks each passing finger token.
// Depends on rftb_pkg.
module rftb_cell #(
    parameter int RING_BITS  = rftb_pkg::RING_BITS_DEFAULT,
    parameter int CELL_INDEX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        load_en,
    input  logic [rftb_pkg::IDX_W-1:0]  load_index,
    input  logic [rftb_pkg::ID_W-1:0]   load_id,
    input  logic [rftb_pkg::CNT_W-1:0]  node_count,
    input  rftb_pkg::token_t            in_ctl,
    input  logic [RING_BITS-1:0]        in_target,
    output rftb_pkg::token_t            out_ctl,
    output logic [RING_BITS-1:0]        out_target
);

    import rftb_pkg::*;

    localparam int CMP_W = (RING_BITS > ID_W) ? RING_BITS : ID_W;
    localparam logic [CNT_W-1:0] MY_COUNT = CNT_W'(CELL_INDEX);
    localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(CELL_INDEX);
    localparam bit IS_FIRST = (CELL_INDEX == 0);

    logic [ID_W-1:0]      id_reg;
    token_t               ctl_reg;
    token_t               ctl_next;
    logic [RING_BITS-1:0] target_reg;
    logic                 in_range;
    logic                 hit;

    // Stored identifier, written by a load request addressed to this entry.
    always_ff @(posedge clk)
    begin
        if (load_en && (load_index == MY_INDEX))
        begin
            id_reg <= load_id;
        end
    end

    // Match the passing token. Entry 0 also supplies the fallback successor.
    assign in_range = (MY_COUNT < node_count);
    assign hit = in_ctl.valid && !in_ctl.found && in_range &&
                 (CMP_W'(id_reg) >= CMP_W'(in_target));

    always_comb
    begin
        ctl_next = in_ctl;
        if (hit)
        begin
            ctl_next.found = 1'b1;
        end
        if (hit || IS_FIRST)
        begin
            ctl_next.succ_index = MY_INDEX;
            ctl_next.succ_id    = id_reg;
        end
    end

    // Token registers toward the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            target_reg <= in_target;
        end
    end

    assign out_ctl    = ctl_reg;
    assign out_target = target_reg;

endmodule

// ----- src/ring_finger_table_builder.sv -----
// Query: a table read, then one finger token issued per cycle for each of the RING_BITS fingers;
// each token walks a chain of MAX_NODES cells, one cell per cycle, into the result register.
// Tokens, chain and result register all hold while a valid result is stalled; results follow
// one per cycle otherwise, and a query holds off requests until its last result is taken.
// A load writes the table and gives no result. Reset clears control state and sets
// node_count to 256; the table stays undefined.
module ring_finger_table_builder #(
    parameter int RING_BITS = rftb_pkg::RING_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration.
    input  logic                          cfg_we,
    input  logic [rftb_pkg::CNT_W-1:0]    cfg_wdata,
    // Request channel.
    input  logic                          request_valid,
    output logic                          request_stall,
    input  logic                          command,
    input  logic [rftb_pkg::IDX_W-1:0]    entry_index,
    input  logic [rftb_pkg::ID_W-1:0]     node_id,
    // Result channel.
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [rftb_pkg::FINGER_W-1:0] finger_number,
    output logic [rftb_pkg::ID_W-1:0]     target_id,
    output logic [rftb_pkg::IDX_W-1:0]    successor_index,
    output logic [rftb_pkg::ID_W-1:0]     successor_id,
    output logic                          last_finger
);

    import rftb_pkg::*;

    localparam int FW = $clog2(RING_BITS);
    localparam logic [FW-1:0] LAST_FINGER = FW'(RING_BITS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_ISSUE = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [FW-1:0]        finger_reg;
    logic [FW-1:0]        finger_next;
    logic [RING_BITS-1:0] base_reg;
    logic [CNT_W-1:0]     node_count_reg;
    token_t               out_ctl_reg;
    logic [RING_BITS-1:0] out_target_reg;

    logic                 req_accept;
    logic                 load_en;
    logic                 query_start;
    logic                 advance;
    logic                 result_taken;
    logic [ID_W-1:0]      ram_rd_data;

    token_t               chain_ctl    [MAX_NODES+1];
    logic [RING_BITS-1:0] chain_target [MAX_NODES+1];

    // Request handshake: a new request only while nothing is in flight.
    assign request_stall = (state_reg != S_IDLE);
    assign req_accept    = request_valid && !request_stall;
    assign load_en       = req_accept && (command == CMD_LOAD);
    assign query_start   = req_accept && (command == CMD_QUERY);

    // The whole chain moves whenever the result register can take a new value.
    assign advance      = !(out_ctl_reg.valid && result_stall);
    assign result_taken = out_ctl_reg.valid && !result_stall;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            node_count_reg <= cfg_wdata;
        end
    end

    // Copy of the table for looking up the queried entry's own identifier.
    rftb_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_NODES)
    ) u_id_ram (
        .clk     (clk),
        .wr_en   (load_en),
        .wr_addr (entry_index),
        .wr_data (node_id),
        .rd_en   (query_start),
        .rd_addr (entry_index),
        .rd_data (ram_rd_data)
    );

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        finger_next = finger_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (query_start)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                finger_next = '0;
                state_next  = S_ISSUE;
            end
            S_ISSUE:
            begin
                if (advance)
                begin
                    finger_next = finger_reg + FW'(1);
                    if (finger_reg == LAST_FINGER)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                if (result_taken && out_ctl_reg.last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            finger_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            finger_reg <= finger_next;
        end
    end

    // Identifier of the queried entry, captured when the table read returns.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            base_reg <= RING_BITS'(ram_rd_data);
        end
    end

    // Token injected at the head of the chain.
    always_comb
    begin
        chain_ctl[0]            = '0;
        chain_ctl[0].valid      = (state_reg == S_ISSUE);
        chain_ctl[0].last       = (finger_reg == LAST_FINGER);
        chain_ctl[0].finger     = FINGER_W'(finger_reg);
        chain_target[0]         = base_reg + (RING_BITS'(1) << finger_reg);
    end

    // Search chain, one cell per table entry.
    for (genvar k = 0; k < MAX_NODES; k++)
    begin : g_cell
        rftb_cell #(
            .RING_BITS  (RING_BITS),
            .CELL_INDEX (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .load_en    (load_en),
            .load_index (entry_index),
            .load_id    (node_id),
            .node_count (node_count_reg),
            .in_ctl     (chain_ctl[k]),
            .in_target  (chain_target[k]),
            .out_ctl    (chain_ctl[k+1]),
            .out_target (chain_target[k+1])
        );
    end

    // Result register at the end of the chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ctl_reg <= '0;
        end
        else if (advance)
        begin
            out_ctl_reg <= chain_ctl[MAX_NODES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_target_reg <= chain_target[MAX_NODES];
        end
    end

    assign result_valid    = out_ctl_reg.valid;
    assign finger_number   = out_ctl_reg.finger;
    assign target_id       = ID_W'(out_target_reg);
    assign successor_index = out_ctl_reg.succ_index;
    assign successor_id    = out_ctl_reg.succ_id;
    assign last_finger     = out_ctl_reg.last;

endmodule

// ----- src/rftb_checker.sv -----
// Port-level checks for the ring finger table builder, bound to the top level.
// Depends on rftb_pkg and ring_finger_table_builder.
module rftb_checker #(
    parameter int RING_BITS = rftb_pkg::RING_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          request_valid,
    input  logic                          request_stall,
    input  logic                          command,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  logic [rftb_pkg::FINGER_W-1:0] finger_number,
    input  logic [rftb_pkg::ID_W-1:0]     target_id,
    input  logic [rftb_pkg::IDX_W-1:0]    successor_index,
    input  logic [rftb_pkg::ID_W-1:0]     successor_id,
    input  logic                          last_finger
);

    import rftb_pkg::*;

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(target_id) &&
        $stable(successor_index) && $stable(successor_id) && $stable(finger_number))
        else $error("stalled result changed");

    // An accepted query is followed by a stalled request channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        request_valid && !request_stall && (command == CMD_QUERY) |=> request_stall)
        else $error("request taken while a query is in progress");

    // An idle block has no result pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        !request_stall |-> !result_valid)
        else $error("result pending while idle");

    // The marked result is the highest finger.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_finger |-> finger_number == FINGER_W'(RING_BITS - 1))
        else $error("last finger mark on wrong finger");

endmodule

bind ring_finger_table_builder rftb_checker #(.RING_BITS(RING_BITS)) u_rftb_checker (.*);
